// ===== hw/rtl/kbq_pkg.sv =====
package kbq_pkg;

    // Number of bid entries, one cell each.
    localparam int ENTRIES  = 64;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int ACTION_W = 2;
    localparam int USER_W   = 16;
    localparam int ITEM_W   = 16;
    localparam int AMOUNT_W = 31;

    localparam logic [ACTION_W-1:0] ACT_SET    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    // A request as it walks down the row of cells, with what it has
    // gathered so far.
    typedef struct packed {
        logic                active;
        logic [ACTION_W-1:0] action;
        logic [ITEM_W-1:0]   item;
        logic [USER_W-1:0]   user;
        logic [AMOUNT_W-1:0] amount;
        logic                hit;
        logic                free_seen;
        logic [IDX_W-1:0]    free_idx;
        logic                found;
        logic [AMOUNT_W-1:0] best_amount;
        logic [USER_W-1:0]   best_user;
    } kbq_token_t;

    // Write of a new pair into the first free entry.
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [ITEM_W-1:0]   item;
        logic [USER_W-1:0]   user;
        logic [AMOUNT_W-1:0] amount;
    } kbq_wr_t;

    typedef struct packed {
        logic [USER_W-1:0] top_user;
        logic              top_found;
        logic              table_full;
    } kbq_res_t;

endpackage

// ===== hw/rtl/kbq_req_if.sv =====
interface kbq_req_if import kbq_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [USER_W-1:0]   user_id;
    logic [ITEM_W-1:0]   item_id;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, output action, output user_id, output item_id,
                    output amount, input ready);
    modport sink   (input valid, input action, input user_id, input item_id,
                    input amount, output ready);

endinterface

// ===== hw/rtl/kbq_rsp_if.sv =====
interface kbq_rsp_if import kbq_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [USER_W-1:0] top_user;
    logic              top_found;
    logic              table_full;

    modport source (output valid, output top_user, output top_found,
                    output table_full, input ready);
    modport sink   (input valid, input top_user, input top_found,
                    input table_full, output ready);

endinterface

// ===== hw/rtl/kbq_cell.sv =====
module kbq_cell
    import kbq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  kbq_token_t       tok_in,
    input  kbq_wr_t          wr,
    output kbq_token_t       tok_out
);

    logic                valid_reg;
    logic [ITEM_W-1:0]   item_reg;
    logic [USER_W-1:0]   user_reg;
    logic [AMOUNT_W-1:0] amount_reg;
    kbq_token_t          tok_reg;
    kbq_token_t          tok_next;

    logic item_match;
    logic pair_match;
    logic better;
    logic wr_here;

    assign item_match = valid_reg && (item_reg == tok_in.item);
    assign pair_match = item_match && (user_reg == tok_in.user);
    assign better     = !tok_in.found || (amount_reg > tok_in.best_amount) ||
                        ((amount_reg == tok_in.best_amount) &&
                         (user_reg > tok_in.best_user));
    assign wr_here    = wr.en && (wr.idx == cell_idx);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active)
        begin
            case (tok_in.action)
                ACT_SET:
                begin
                    if (pair_match)
                    begin
                        tok_next.hit = 1'b1;
                    end
                    if (!valid_reg && !tok_in.free_seen)
                    begin
                        tok_next.free_seen = 1'b1;
                        tok_next.free_idx  = cell_idx;
                    end
                end
                ACT_REMOVE:
                begin
                    if (pair_match)
                    begin
                        tok_next.hit = 1'b1;
                    end
                end
                ACT_QUERY:
                begin
                    if (item_match && better)
                    begin
                        tok_next.found       = 1'b1;
                        tok_next.best_amount = amount_reg;
                        tok_next.best_user   = user_reg;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_here)
            begin
                valid_reg <= 1'b1;
            end
            else if (tok_in.active && (tok_in.action == ACT_REMOVE) && pair_match)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Entry payload is only read while the entry is valid.
    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            item_reg   <= wr.item;
            user_reg   <= wr.user;
            amount_reg <= wr.amount;
        end
        else if (tok_in.active && (tok_in.action == ACT_SET) && pair_match)
        begin
            amount_reg <= tok_in.amount;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== hw/rtl/kbq_chain.sv =====
module kbq_chain
    import kbq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  kbq_token_t head,
    input  kbq_wr_t    wr,
    output kbq_token_t tail
);

    kbq_token_t link [ENTRIES+1];

    assign link[0] = head;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kbq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .tok_in   (link[i]),
            .wr       (wr),
            .tok_out  (link[i+1])
        );
    end

    assign tail = link[ENTRIES];

endmodule

// ===== hw/rtl/keyed_bid_table_highest_query_core.sv =====
// Channel  Role  Handshake     Payload
// req      sink  valid/ready   action, user_id, item_id, amount
// rsp      src   valid/ready   top_user, top_found, table_full
//
// Each request walks the row of ENTRIES cells, one cell per cycle, and its
// response is then registered. Only one request is in the row at a time;
// the next one is accepted as soon as the previous response has been
// loaded into the output register, even if it has not been taken yet.
// Reset clears all entry valid bits at once, with no clearing pass. A
// stalled response is held in the output register, and a second finished
// response waits in a holding register until it can move.
module keyed_bid_table_highest_query_core
    import kbq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    kbq_req_if.sink   req,
    kbq_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t     state_reg;
    kbq_token_t launch_reg;
    kbq_token_t launch_next;
    kbq_token_t tail;
    kbq_wr_t    wr;
    kbq_res_t   res_now;
    kbq_res_t   hold_reg;
    kbq_res_t   out_reg;
    logic       out_valid_reg;
    logic       req_accept;
    logic       out_free;
    logic       out_load;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;

    // The request enters the row as a token with nothing gathered yet.
    always_comb
    begin
        launch_next = '0;
        if (req_accept)
        begin
            launch_next.active = 1'b1;
            launch_next.action = req.action;
            launch_next.item   = req.item_id;
            launch_next.user   = req.user_id;
            launch_next.amount = req.amount;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= '0;
        end
        else
        begin
            launch_reg <= launch_next;
        end
    end

    kbq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (launch_reg),
        .wr    (wr),
        .tail  (tail)
    );

    // When a set leaves the row without having found its pair, it is
    // written into the lowest free entry that it saw, or dropped if the
    // row had no free entry.
    always_comb
    begin
        wr        = '0;
        wr.en     = tail.active && (tail.action == ACT_SET) && !tail.hit &&
                    tail.free_seen;
        wr.idx    = tail.free_idx;
        wr.item   = tail.item;
        wr.user   = tail.user;
        wr.amount = tail.amount;
    end

    always_comb
    begin
        res_now            = '0;
        res_now.top_found  = (tail.action == ACT_QUERY) && tail.found;
        res_now.top_user   = res_now.top_found ? tail.best_user : '0;
        res_now.table_full = (tail.action == ACT_SET) && !tail.hit &&
                             !tail.free_seen;
    end

    assign out_free = !out_valid_reg || rsp.ready;

    // The output register takes a new response when one is finished, either
    // straight from the row or from the holding register, and it is free.
    assign out_load = out_free &&
                      (((state_reg == ST_RUN) && tail.active) || (state_reg == ST_HOLD));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            hold_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_accept)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (tail.active)
                    begin
                        if (out_free)
                        begin
                            out_reg   <= res_now;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            hold_reg  <= res_now;
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_reg   <= hold_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.top_user   = out_reg.top_user;
    assign rsp.top_found  = out_reg.top_found;
    assign rsp.table_full = out_reg.table_full;

    // A request leaves the row only while the controller waits for it.
    a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> (state_reg == ST_RUN))
        else $error("request left the cell row outside of a run");

    // While idle, no request is in flight at the end of the row.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !tail.active)
        else $error("cell row busy while controller idle");

    // An accepted request starts a run on the next cycle.
    a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (state_reg == ST_RUN) && launch_reg.active)
        else $error("accepted request did not enter the cell row");

    // A dropped set never reports a bidder.
    a_full_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.table_full) |-> !rsp.top_found)
        else $error("response is both full and found");

endmodule

// ===== bench/keyed_bid_table_highest_query_core_tb.sv =====
`timescale 1ns / 100ps

// Bench for the keyed bid table. The bench keeps its own copy of the bid
// table and works out the response of every request when the core accepts
// it. A clocked driver feeds requests from a queue. A clocked monitor checks
// each response against the oldest outstanding prediction. Both channels
// idle at random. Once during the run the response side holds off for a long
// stretch, so the core fills its output registers and stalls its input.
module keyed_bid_table_highest_query_core_tb
    import kbq_pkg::*;
;

    // Action code 3 is not used by the core: it changes nothing and answers
    // with an all-zero response.
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = {AMOUNT_W{1'b1}};
    localparam logic [ITEM_W-1:0]   ITEM_MAX   = {ITEM_W{1'b1}};
    localparam logic [USER_W-1:0]   USER_MAX   = {USER_W{1'b1}};

    localparam int RANDOM_REQUESTS = 1000;
    localparam int CHUNK           = 40;
    localparam int HOLD_CYCLES     = 400;
    // The drain covers the walk of a request down the row of ENTRIES cells.
    localparam int DRAIN_CYCLES    = ENTRIES + 20;
    // A cycle with no handshake on either channel counts toward the limit.
    // The long hold-off is the longest legal quiet stretch.
    localparam int STALL_LIMIT     = 4000;
    localparam int MAX_REPORTS     = 40;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [USER_W-1:0]   user;
        logic [ITEM_W-1:0]   item;
        logic [AMOUNT_W-1:0] amount;
    } bid_req_t;

    logic clk;
    logic rst_n;

    kbq_req_if req ();
    kbq_rsp_if rsp ();

    keyed_bid_table_highest_query_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Bench copy of the bid table.
    logic                bid_valid  [ENTRIES];
    logic [ITEM_W-1:0]   bid_item   [ENTRIES];
    logic [USER_W-1:0]   bid_user   [ENTRIES];
    logic [AMOUNT_W-1:0] bid_amount [ENTRIES];

    bid_req_t pending_reqs[$];
    kbq_res_t pending_results[$];

    logic [ITEM_W-1:0] item_pool [8];
    logic [USER_W-1:0] user_pool [12];

    int  error_count   = 0;
    int  results_seen  = 0;
    int  drv_wait      = 0;
    int  drv_calm      = 0;
    int  rx_wait       = 0;
    int  rx_calm       = 0;
    int  quiet_cycles  = 0;
    logic rsp_hold     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset is applied once. The request channel and the response ready are
    // given known values from time zero on.
    initial
    begin
        rst_n      = 1'b0;
        req.valid  = 1'b0;
        req.action = '0;
        req.user_id = '0;
        req.item_id = '0;
        req.amount = '0;
        rsp.ready  = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            bid_valid[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Applies one request to the bench table and returns the response the
    // core must give for it. A set looks for its pair first and otherwise
    // takes the lowest free entry; with no free entry the bid is dropped and
    // the full flag is raised. A query keeps the largest amount, and on equal
    // amounts the larger user id.
    function automatic kbq_res_t apply_bid_request(input bid_req_t r);
        kbq_res_t            res;
        int                  slot;
        logic [AMOUNT_W-1:0] best;
        res  = '0;
        slot = -1;
        best = '0;
        if (r.action == ACT_SET || r.action == ACT_REMOVE)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot < 0 && bid_valid[i] && bid_item[i] == r.item
                    && bid_user[i] == r.user)
                begin
                    slot = i;
                end
            end
        end
        case (r.action)
            ACT_SET:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot < 0 && !bid_valid[i])
                    begin
                        slot = i;
                    end
                end
                if (slot < 0)
                begin
                    res.table_full = 1'b1;
                end
                else
                begin
                    bid_valid[slot]  = 1'b1;
                    bid_item[slot]   = r.item;
                    bid_user[slot]   = r.user;
                    bid_amount[slot] = r.amount;
                end
            end
            ACT_REMOVE:
            begin
                if (slot >= 0)
                begin
                    bid_valid[slot] = 1'b0;
                end
            end
            ACT_QUERY:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (bid_valid[i] && bid_item[i] == r.item)
                    begin
                        if (!res.top_found || bid_amount[i] > best
                            || (bid_amount[i] == best && bid_user[i] > res.top_user))
                        begin
                            res.top_found = 1'b1;
                            best          = bid_amount[i];
                            res.top_user  = bid_user[i];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Idle length for one request or response. Now and then a stretch of
    // back-to-back traffic with no idling at all is started.
    function automatic int idle_cycles(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 40);
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic push_request(input logic [ACTION_W-1:0] action,
                                input logic [USER_W-1:0] user,
                                input logic [ITEM_W-1:0] item,
                                input logic [AMOUNT_W-1:0] amount);
        bid_req_t r;
        r.action = action;
        r.user   = user;
        r.item   = item;
        r.amount = amount;
        pending_reqs.push_back(r);
    endtask

    // Keys come mostly from small pools, so pairs repeat, queries find bids
    // and the table runs full. The rest are fully random.
    function automatic logic [ITEM_W-1:0] pick_item();
        if ($urandom_range(0, 9) < 9)
        begin
            return item_pool[$urandom_range(0, 7)];
        end
        return ITEM_W'($urandom_range(0, 32'hFFFF));
    endfunction

    function automatic logic [USER_W-1:0] pick_user();
        if ($urandom_range(0, 9) < 9)
        begin
            return user_pool[$urandom_range(0, 11)];
        end
        return USER_W'($urandom_range(0, 32'hFFFF));
    endfunction

    // Small amounts make ties between users common.
    function automatic logic [AMOUNT_W-1:0] pick_amount();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            return AMOUNT_W'($urandom_range(0, 3));
        end
        if (sel == 4)
        begin
            return AMOUNT_MAX;
        end
        return AMOUNT_W'($urandom());
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
        begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    // Stimulus: a short directed part, then random chunks whose mix of sets,
    // removes and queries changes from chunk to chunk. Chunks heavy in sets
    // drive the table full; chunks heavy in removes drain it again.
    initial
    begin
        int set_pct;
        int remove_pct;
        int sel;

        item_pool[0] = '0;
        item_pool[1] = ITEM_MAX;
        user_pool[0] = '0;
        user_pool[1] = USER_MAX;
        for (int i = 2; i < 8; i++)
        begin
            item_pool[i] = ITEM_W'($urandom_range(0, 32'hFFFF));
        end
        for (int i = 2; i < 12; i++)
        begin
            user_pool[i] = USER_W'($urandom_range(0, 32'hFFFF));
        end

        // Query on an empty table.
        push_request(ACT_QUERY, '0, '0, '0);
        // A bid of zero by user zero still counts as found.
        push_request(ACT_SET, '0, '0, '0);
        push_request(ACT_QUERY, '0, '0, '0);
        // Equal top amounts: the larger user id wins.
        push_request(ACT_SET, USER_MAX, ITEM_MAX, AMOUNT_MAX);
        push_request(ACT_SET, 16'h0001, ITEM_MAX, AMOUNT_MAX);
        push_request(ACT_QUERY, '0, ITEM_MAX, '0);
        // Replacing a bid lowers it below the other user.
        push_request(ACT_SET, USER_MAX, ITEM_MAX, 31'd5);
        push_request(ACT_QUERY, 16'h1234, ITEM_MAX, AMOUNT_MAX);
        push_request(ACT_REMOVE, 16'h0001, ITEM_MAX, AMOUNT_MAX);
        push_request(ACT_QUERY, '0, ITEM_MAX, '0);
        // Removing a pair that is not there changes nothing; then user zero's bid on item zero goes.
        push_request(ACT_REMOVE, 16'h0007, '0, '0);
        push_request(ACT_REMOVE, '0, '0, '0);
        push_request(ACT_QUERY, USER_MAX, '0, '0);
        // The unused action code with busy fields.
        push_request(ACT_NONE, USER_MAX, ITEM_MAX, AMOUNT_MAX);
        push_request(ACT_NONE, '0, '0, '0);
        // Three bidders on one item, two of them tied.
        push_request(ACT_SET, 16'h0100, 16'h1234, 31'd100);
        push_request(ACT_SET, 16'h0200, 16'h1234, 31'd100);
        push_request(ACT_SET, 16'h0300, 16'h1234, 31'd99);
        push_request(ACT_QUERY, USER_MAX, 16'h1234, AMOUNT_MAX);
        push_request(ACT_REMOVE, 16'h0200, 16'h1234, AMOUNT_MAX);
        push_request(ACT_QUERY, '0, 16'h1234, '0);
        push_request(ACT_SET, 16'hAAAA, 16'h5555, 31'h2AAA_AAAA);
        push_request(ACT_QUERY, '0, 16'h5555, '0);

        for (int n = 0; n < RANDOM_REQUESTS; n += CHUNK)
        begin
            case ($urandom_range(0, 3))
                0: set_pct = 25;
                1: set_pct = 50;
                2: set_pct = 75;
                default: set_pct = 90;
            endcase
            remove_pct = (100 - set_pct) / 2;
            for (int k = 0; k < CHUNK; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 2)
                begin
                    push_request(ACT_NONE, USER_W'($urandom()), ITEM_W'($urandom()),
                                 AMOUNT_W'($urandom()));
                end
                else if (sel < set_pct)
                begin
                    push_request(ACT_SET, pick_user(), pick_item(), pick_amount());
                end
                else if (sel < set_pct + remove_pct)
                begin
                    push_request(ACT_REMOVE, pick_user(), pick_item(), pick_amount());
                end
                else
                begin
                    push_request(ACT_QUERY, pick_user(), pick_item(), pick_amount());
                end
            end
        end

        @(posedge clk);
        while (pending_reqs.size() != 0 || req.valid || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("keyed_bid_table_highest_query_core_tb OK");
        end
        else
        begin
            $display("keyed_bid_table_highest_query_core_tb NOT OK");
        end
        $finish;
    end

    // Request driver. After a request is taken the driver idles for a drawn
    // number of cycles, counted only while the core is ready, so the gap
    // really delays the core. A request stays on the channel until taken.
    always @(posedge clk or negedge rst_n)
    begin
        int       gap;
        bid_req_t nxt;
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.action  <= '0;
            req.user_id <= '0;
            req.item_id <= '0;
            req.amount  <= '0;
            drv_wait    <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            gap = drv_wait;
            if (req.valid)
            begin
                gap = idle_cycles(drv_calm);
            end
            else if (gap > 0 && req.ready)
            begin
                gap--;
            end
            if (gap == 0 && pending_reqs.size() != 0)
            begin
                nxt          = pending_reqs.pop_front();
                req.valid   <= 1'b1;
                req.action  <= nxt.action;
                req.user_id <= nxt.user;
                req.item_id <= nxt.item;
                req.amount  <= nxt.amount;
            end
            else
            begin
                req.valid <= 1'b0;
            end
            drv_wait <= gap;
        end
    end

    // Response receiver. After each response it drops ready for a drawn
    // number of cycles. During the long hold-off it keeps ready low.
    always @(posedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rx_wait   <= 0;
        end
        else if (rsp.valid && rsp.ready)
        begin
            w = idle_cycles(rx_calm);
            rx_wait   <= w;
            rsp.ready <= (w == 0) && !rsp_hold;
        end
        else if (rx_wait > 0)
        begin
            rx_wait   <= rx_wait - 1;
            rsp.ready <= (rx_wait == 1) && !rsp_hold;
        end
        else
        begin
            rsp.ready <= !rsp_hold;
        end
    end

    // Long hold-off on the response side while the driver keeps offering
    // requests: the output and holding registers fill and the core must
    // stall its request channel.
    initial
    begin
        wait (results_seen >= 150);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Monitor. A request taken at this edge is applied to the bench table
    // and its response is queued; a response taken at this edge is checked
    // field by field against the oldest queued one.
    always @(posedge clk)
    begin
        bid_req_t seen;
        kbq_res_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                seen.action = req.action;
                seen.user   = req.user_id;
                seen.item   = req.item_id;
                seen.amount = req.amount;
                pending_results.push_back(apply_bid_request(seen));
            end
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("response with no request outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.top_user !== want.top_user)
                    begin
                        report_mismatch($sformatf("top_user got %h want %h",
                                                  rsp.top_user, want.top_user));
                    end
                    if (rsp.top_found !== want.top_found)
                    begin
                        report_mismatch($sformatf("top_found got %b want %b",
                                                  rsp.top_found, want.top_found));
                    end
                    if (rsp.table_full !== want.table_full)
                    begin
                        report_mismatch($sformatf("table_full got %b want %b",
                                                  rsp.table_full, want.table_full));
                    end
                end
            end
        end
    end

    // Watchdog: too long without a handshake on either channel ends the run.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("keyed_bid_table_highest_query_core_tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
